/* src/dgtb_pkg.sv */
// Package for the dual group timer bank: sizes, operation codes, the
// channel memory entry type and the controller state type.
// No dependencies.
package dgtb_pkg;

  localparam int UP_CHANNELS   = 8;
  localparam int DOWN_CHANNELS = 8;
  localparam int COUNT_BITS    = 10;

  localparam int ALL_CHANNELS = UP_CHANNELS + DOWN_CHANNELS;
  localparam int CH_W         = (ALL_CHANNELS > 1) ? $clog2(ALL_CHANNELS) : 1;
  localparam int CNT_W        = COUNT_BITS + 1;

  // Fixed field widths of the channels
  localparam int OP_W        = 2;
  localparam int CHAN_W      = 4;
  localparam int TIME_W      = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int MASK_W      = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_ACCESS
  } st_e;

  // One channel's memory entry; limit is only used by up channels
  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [COUNT_BITS-1:0] limit;
  } entry_t;

  // Channel field to memory address (zero-extend or truncate)
  function automatic logic [CH_W-1:0] chan_addr(input logic [CHAN_W-1:0] c);
    logic [CH_W-1:0] a;
    a = '0;
    for (int i = 0; i < CH_W; i++) begin
      if (i < CHAN_W) begin
        a[i] = c[i];
      end
    end
    return a;
  endfunction

endpackage

/* src/dgtb_in_if.sv */
// Input channel interface of the timer bank: valid/ready and the item fields.
// Depends on dgtb_pkg.
interface dgtb_in_if;
  logic                         valid;
  logic                         ready;
  logic [dgtb_pkg::OP_W-1:0]    op;
  logic [dgtb_pkg::CHAN_W-1:0]  channel;
  logic                         enable_value;
  logic [dgtb_pkg::TIME_W-1:0]  time_value;

  modport source (output valid, output op, output channel, output enable_value,
                  output time_value, input ready);
  modport sink   (input valid, input op, input channel, input enable_value,
                  input time_value, output ready);
endinterface

/* src/dgtb_out_if.sv */
// Result channel interface of the timer bank: valid/ready and result fields.
// Depends on dgtb_pkg.
interface dgtb_out_if;
  logic                              valid;
  logic                              ready;
  logic [dgtb_pkg::COUNT_OUT_W-1:0]  count_value;
  logic                              enabled;
  logic                              done_res;
  logic [dgtb_pkg::MASK_W-1:0]       done_mask;

  modport source (output valid, output count_value, output enabled,
                  output done_res, output done_mask, input ready);
  modport sink   (input valid, input count_value, input enabled,
                  input done_res, input done_mask, output ready);
endinterface

/* src/dual_group_timer_bank_core.sv */
// Dual group timer bank: counts and limits in a channel memory (registered read),
// enable and done flags in flops. One item in flight at a time.
// Tick: one channel read-modify-written per cycle, the last channel waiting for
// a free result register.
// Reset clears flags and controller; memory entries read as zero until written
// (per-entry valid flops), so no clearing pass is needed.
module dual_group_timer_bank_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  dgtb_in_if.sink      in_i,
  dgtb_out_if.source   out_o
);

  localparam logic [dgtb_pkg::CH_W-1:0] LAST_CH =
    dgtb_pkg::CH_W'(dgtb_pkg::ALL_CHANNELS - 1);

  dgtb_pkg::st_e state_q, state_d;
  logic [dgtb_pkg::CH_W-1:0] idx_q, idx_d;

  // captured item
  logic [dgtb_pkg::OP_W-1:0]       op_q;
  logic [dgtb_pkg::CH_W-1:0]       ch_q;
  logic                            ch_ok_q;
  logic                            en_val_q;
  logic [dgtb_pkg::COUNT_BITS-1:0] tv_q;
  logic [63:0]                     tv_wide;

  // channel memory
  dgtb_pkg::entry_t                 mem [dgtb_pkg::ALL_CHANNELS];
  logic [dgtb_pkg::ALL_CHANNELS-1:0] mvld_q;
  dgtb_pkg::entry_t                 rdata_q;
  logic                             rvld_q;
  logic [dgtb_pkg::CH_W-1:0]        rd_addr, wr_addr;
  logic                             we;
  dgtb_pkg::entry_t                 cur;

  logic [dgtb_pkg::ALL_CHANNELS-1:0] en_q, en_d, done_q, done_d;
  logic [dgtb_pkg::CNT_W-1:0]        cap_q, cap_d;

  // channel update
  logic [dgtb_pkg::CH_W-1:0]  p_addr;
  dgtb_pkg::op_e              p_op;
  logic                       p_up;
  dgtb_pkg::entry_t           nxt;
  logic                       nen, ndone;
  logic [dgtb_pkg::CNT_W-1:0] inc;

  // result register
  logic                              out_vld_q;
  logic [dgtb_pkg::COUNT_OUT_W-1:0]  out_cnt_q;
  logic                              out_en_q, out_done_q;
  logic [dgtb_pkg::MASK_W-1:0]       out_mask_q;
  logic                              out_free, out_load;
  logic [dgtb_pkg::CNT_W-1:0]        res_cnt;
  logic [63:0]                       res_wide, done_wide;

  assign cur      = rvld_q ? rdata_q : '0;
  assign out_free = !out_vld_q || out_o.ready;
  assign tv_wide  = 64'(in_i.time_value);

  // Next entry and flags of the channel being processed
  always_comb begin
    p_addr = (state_q == dgtb_pkg::ST_TICK) ? idx_q : ch_q;
    p_op   = (state_q == dgtb_pkg::ST_TICK) ? dgtb_pkg::OP_TICK
                                             : dgtb_pkg::op_e'(op_q);
    p_up   = int'(p_addr) < dgtb_pkg::UP_CHANNELS;
    nxt    = cur;
    nen    = en_q[p_addr];
    ndone  = done_q[p_addr];
    inc    = cur.count + 1'b1;
    case (p_op)
      dgtb_pkg::OP_TICK: begin
        if (!nen) begin
          nxt.count = '0;
        end else if (p_up) begin
          if (inc > dgtb_pkg::CNT_W'(cur.limit)) begin
            nxt.count = '0;
            ndone     = 1'b1;
          end else begin
            nxt.count = inc;
          end
        end else if (cur.count != '0) begin
          nxt.count = cur.count - 1'b1;
        end else begin
          nen   = 1'b0;
          ndone = 1'b1;
        end
      end
      dgtb_pkg::OP_WRITE: begin
        nen = en_val_q;
        if (p_up) begin
          nxt.limit = tv_q;
          nxt.count = '0;
        end else begin
          nxt.count = dgtb_pkg::CNT_W'(tv_q);
        end
      end
      dgtb_pkg::OP_CLEAR: begin
        ndone = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Controller
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    en_d      = en_q;
    done_d    = done_q;
    cap_d     = cap_q;
    we        = 1'b0;
    wr_addr   = p_addr;
    rd_addr   = idx_q;
    in_i.ready = 1'b0;
    out_load  = 1'b0;
    res_cnt   = nxt.count;
    case (state_q)
      dgtb_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_addr = (in_i.op == dgtb_pkg::OP_TICK) ? '0
                                                 : dgtb_pkg::chan_addr(in_i.channel);
        idx_d = '0;
        if (in_i.valid) begin
          state_d = (in_i.op == dgtb_pkg::OP_TICK) ? dgtb_pkg::ST_TICK
                                                   : dgtb_pkg::ST_ACCESS;
        end
      end
      dgtb_pkg::ST_TICK: begin
        // the last channel waits for a free result register
        if (idx_q != LAST_CH || out_free) begin
          we             = 1'b1;
          en_d[idx_q]    = nen;
          done_d[idx_q]  = ndone;
          if (idx_q == ch_q) begin
            cap_d = nxt.count;
          end
          if (idx_q == LAST_CH) begin
            out_load = 1'b1;
            res_cnt  = (idx_q == ch_q) ? nxt.count : cap_q;
            state_d  = dgtb_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_addr = idx_q + 1'b1;
          end
        end
      end
      dgtb_pkg::ST_ACCESS: begin
        rd_addr = ch_q;
        if (out_free) begin
          if (ch_ok_q) begin
            we           = 1'b1;
            en_d[ch_q]   = nen;
            done_d[ch_q] = ndone;
          end
          out_load = 1'b1;
          state_d  = dgtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dgtb_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_wide  = 64'(res_cnt);
  assign done_wide = 64'(done_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dgtb_pkg::ST_IDLE;
      idx_q     <= '0;
      en_q      <= '0;
      done_q    <= '0;
      mvld_q    <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      en_q    <= en_d;
      done_q  <= done_d;
      rvld_q  <= mvld_q[rd_addr];
      if (we) begin
        mvld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Channel memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= nxt;
    end
    rdata_q <= mem[rd_addr];
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
    if (in_i.valid && in_i.ready) begin
      op_q     <= in_i.op;
      ch_q     <= dgtb_pkg::chan_addr(in_i.channel);
      ch_ok_q  <= int'(in_i.channel) < dgtb_pkg::ALL_CHANNELS;
      en_val_q <= in_i.enable_value;
      tv_q     <= tv_wide[dgtb_pkg::COUNT_BITS-1:0];
    end
    if (out_load) begin
      out_cnt_q  <= ch_ok_q ? res_wide[dgtb_pkg::COUNT_OUT_W-1:0] : '0;
      out_en_q   <= ch_ok_q && en_d[ch_q];
      out_done_q <= ch_ok_q && done_d[ch_q];
      out_mask_q <= done_wide[dgtb_pkg::MASK_W-1:0];
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.count_value = out_cnt_q;
  assign out_o.enabled     = out_en_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.done_mask   = out_mask_q;

endmodule

/* tb/tb_dual_group_timer_bank_core.sv */
`timescale 1ns / 1ps
// Testbench for dual_group_timer_bank_core: directed and random command traffic,
// checked one status at a time against a behavioral timer bank kept in this file.
// Depends on dgtb_pkg, dgtb_in_if, dgtb_out_if and the core.
module tb_dual_group_timer_bank_core;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTED  = 30;
  localparam int RANDOM_PER_PH = 150;

  typedef struct packed {
    dgtb_pkg::op_e                op;
    logic [dgtb_pkg::CHAN_W-1:0]  channel;
    logic                         enable_value;
    logic [dgtb_pkg::TIME_W-1:0]  time_value;
  } cmd_t;

  typedef struct packed {
    logic [dgtb_pkg::COUNT_OUT_W-1:0] count_value;
    logic                             enabled;
    logic                             done_res;
    logic [dgtb_pkg::MASK_W-1:0]      done_mask;
  } status_t;

  logic clk_i;
  logic rst_ni;

  dgtb_in_if  in_if ();
  dgtb_out_if out_if ();

  dual_group_timer_bank_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Behavioral copy of the timer bank
  logic [dgtb_pkg::CNT_W-1:0]      up_cnt   [dgtb_pkg::UP_CHANNELS];
  logic [dgtb_pkg::COUNT_BITS-1:0] up_lim   [dgtb_pkg::UP_CHANNELS];
  logic [dgtb_pkg::COUNT_BITS-1:0] down_cnt [dgtb_pkg::DOWN_CHANNELS];
  logic                            chan_en  [dgtb_pkg::ALL_CHANNELS];
  logic                            chan_done[dgtb_pkg::ALL_CHANNELS];

  status_t expected_status_q[$];

  int unsigned cycle_cnt;
  int unsigned error_cnt;
  int unsigned cmds_sent;
  int unsigned ticks_sent;
  int unsigned status_checked;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d status results outstanding", cycle_cnt,
             expected_status_q.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic cmd_t make_cmd(dgtb_pkg::op_e op, int ch, bit en, int tv);
    cmd_t c;
    c.op           = op;
    c.channel      = ch[dgtb_pkg::CHAN_W-1:0];
    c.enable_value = en;
    c.time_value   = tv[dgtb_pkg::TIME_W-1:0];
    return c;
  endfunction

  // Applies one command to the timer bank copy and returns the status it yields
  function automatic status_t timer_bank_step(cmd_t c);
    status_t                     s;
    logic [dgtb_pkg::TIME_W-1:0] tv;
    int                          ch;
    bit                          in_bank;
    ch      = c.channel;
    in_bank = ch < dgtb_pkg::ALL_CHANNELS;
    for (int i = 0; i < dgtb_pkg::TIME_W; i++) begin
      tv[i] = c.time_value[i] && (i < dgtb_pkg::COUNT_BITS);
    end
    case (c.op)
      dgtb_pkg::OP_TICK: begin
        for (int i = 0; i < dgtb_pkg::UP_CHANNELS; i++) begin
          if (chan_en[i]) begin
            up_cnt[i] = up_cnt[i] + 1'b1;
            if (up_cnt[i] > up_lim[i]) begin
              up_cnt[i]    = '0;
              chan_done[i] = 1'b1;
            end
          end else begin
            up_cnt[i] = '0;
          end
        end
        for (int i = 0; i < dgtb_pkg::DOWN_CHANNELS; i++) begin
          if (chan_en[dgtb_pkg::UP_CHANNELS+i]) begin
            if (down_cnt[i] != '0) begin
              down_cnt[i] = down_cnt[i] - 1'b1;
            end else begin
              // one-shot expired
              chan_en[dgtb_pkg::UP_CHANNELS+i]   = 1'b0;
              chan_done[dgtb_pkg::UP_CHANNELS+i] = 1'b1;
            end
          end else begin
            down_cnt[i] = '0;
          end
        end
      end
      dgtb_pkg::OP_WRITE: begin
        if (in_bank) begin
          chan_en[ch] = c.enable_value;
          if (ch < dgtb_pkg::UP_CHANNELS) begin
            up_lim[ch] = tv[dgtb_pkg::COUNT_BITS-1:0];
            up_cnt[ch] = '0;
          end else begin
            down_cnt[ch-dgtb_pkg::UP_CHANNELS] = tv[dgtb_pkg::COUNT_BITS-1:0];
          end
        end
      end
      dgtb_pkg::OP_CLEAR: begin
        if (in_bank) chan_done[ch] = 1'b0;
      end
      default: ;
    endcase
    s = '0;
    if (in_bank) begin
      s.count_value = (ch < dgtb_pkg::UP_CHANNELS) ?
                      dgtb_pkg::COUNT_OUT_W'(up_cnt[ch]) :
                      dgtb_pkg::COUNT_OUT_W'(down_cnt[ch-dgtb_pkg::UP_CHANNELS]);
      s.enabled     = chan_en[ch];
      s.done_res    = chan_done[ch];
    end
    for (int i = 0; i < dgtb_pkg::ALL_CHANNELS && i < dgtb_pkg::MASK_W; i++) begin
      s.done_mask[i] = chan_done[i];
    end
    return s;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    error_cnt++;
    if (error_cnt <= MAX_REPORTED) begin
      $display("[%0t] status #%0d %s: expected 0x%0h, got 0x%0h", $time, status_checked,
               field, exp_v, got_v);
    end
  endtask

  // Drives one command, waits for its transaction and records the expected status
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= c.op;
    in_if.channel      <= c.channel;
    in_if.enable_value <= c.enable_value;
    in_if.time_value   <= c.time_value;
    do @(posedge clk_i); while (!in_if.ready);
    expected_status_q.push_back(timer_bank_step(c));
    cmds_sent++;
    if (c.op == dgtb_pkg::OP_TICK) ticks_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_t random_cmd();
    int unsigned r;
    int unsigned tv;
    r  = $urandom_range(99);
    tv = ($urandom_range(99) < 70) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    if (r < 40) return make_cmd(dgtb_pkg::OP_TICK, $urandom_range(0, 15),
                                $urandom_range(0, 1), tv);
    if (r < 65) return make_cmd(dgtb_pkg::OP_WRITE, $urandom_range(0, 15),
                                $urandom_range(99) < 85, tv);
    if (r < 85) return make_cmd(dgtb_pkg::OP_READ, $urandom_range(0, 15),
                                $urandom_range(0, 1), tv);
    return make_cmd(dgtb_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 1), tv);
  endfunction

  // Status checker
  initial begin : status_check
    status_t exp_s;
    status_t got_s;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got_s = {out_if.count_value, out_if.enabled, out_if.done_res, out_if.done_mask};
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'd0, 32'(got_s.done_mask));
        end else begin
          exp_s = expected_status_q.pop_front();
          if (got_s.count_value !== exp_s.count_value)
            report_mismatch("count_value", 32'(exp_s.count_value), 32'(got_s.count_value));
          if (got_s.enabled !== exp_s.enabled)
            report_mismatch("enabled", 32'(exp_s.enabled), 32'(got_s.enabled));
          if (got_s.done_res !== exp_s.done_res)
            report_mismatch("done_res", 32'(exp_s.done_res), 32'(got_s.done_res));
          if (got_s.done_mask !== exp_s.done_mask)
            report_mismatch("done_mask", 32'(exp_s.done_mask), 32'(got_s.done_mask));
        end
        status_checked++;
      end
    end
  end

  // Result-side ready: random stalls plus an optional long hold-off
  initial begin : status_ready
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(make_cmd(dgtb_pkg::OP_READ, 0, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_READ, 15, 1, 1023));
  endtask

  task automatic test_up_channels();
    // zero limit: every tick wraps and sets done
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 0, 1, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_TICK, 0, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_TICK, 0, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 7, 1, 1023));
    send_cmd(make_cmd(dgtb_pkg::OP_READ, 7, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 3, 1, 2));
    repeat (3) send_cmd(make_cmd(dgtb_pkg::OP_TICK, 3, 0, 0));
    // disabling keeps done, count back to zero
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 3, 0, 5));
  endtask

  task automatic test_down_channels();
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 8, 1, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_TICK, 8, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 15, 1, 1023));
    send_cmd(make_cmd(dgtb_pkg::OP_TICK, 15, 0, 0));
    // count loaded while disabled is visible until the next tick
    send_cmd(make_cmd(dgtb_pkg::OP_WRITE, 12, 0, 500));
    send_cmd(make_cmd(dgtb_pkg::OP_READ, 12, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_TICK, 12, 0, 0));
  endtask

  task automatic test_clear_done();
    send_cmd(make_cmd(dgtb_pkg::OP_CLEAR, 0, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_CLEAR, 8, 1, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_CLEAR, 5, 0, 0));
    send_cmd(make_cmd(dgtb_pkg::OP_READ, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall, int n);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_cmd(random_cmd());
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 150;
    repeat (20) send_cmd(random_cmd());
  endtask

  task automatic test_drain_pause();
    idle_pct  = 16;
    stall_pct = 16;
    repeat (2) begin
      repeat (10) send_cmd(random_cmd());
      wait_drained();
    end
  endtask

  initial begin : main
    rst_ni             = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= dgtb_pkg::OP_READ;
    in_if.channel      <= '0;
    in_if.enable_value <= 1'b0;
    in_if.time_value   <= '0;
    error_cnt          = 0;
    cmds_sent          = 0;
    ticks_sent         = 0;
    status_checked     = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_left          = 0;
    for (int i = 0; i < dgtb_pkg::UP_CHANNELS; i++) begin
      up_cnt[i] = '0;
      up_lim[i] = '0;
    end
    for (int i = 0; i < dgtb_pkg::DOWN_CHANNELS; i++) down_cnt[i] = '0;
    for (int i = 0; i < dgtb_pkg::ALL_CHANNELS; i++) begin
      chan_en[i]   = 1'b0;
      chan_done[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_up_channels();
    test_down_channels();
    test_clear_done();
    test_random_traffic(0, 0, RANDOM_PER_PH);
    test_random_traffic(55, 0, RANDOM_PER_PH);
    test_random_traffic(0, 55, RANDOM_PER_PH);
    test_random_traffic(16, 16, RANDOM_PER_PH);
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d commands (%0d ticks) over idle/stall phases, a long result",
             cmds_sent, ticks_sent);
    $display("hold-off and drain pauses; %0d status results checked, %0d mismatches",
             status_checked, error_cnt);
    if (error_cnt == 0 && expected_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dgtb_pkg.sv
src/dgtb_in_if.sv
src/dgtb_out_if.sv
src/dual_group_timer_bank_core.sv
tb/tb_dual_group_timer_bank_core.sv
